FILE: design/sss_pkg.sv
// Shared types and constants for the state-space step block.
// No dependencies.
package sss_pkg;

	localparam logic [1:0] ACT_SAMPLE = 2'd0;
	localparam logic [1:0] ACT_COEF   = 2'd1;
	localparam logic [1:0] ACT_STATE  = 2'd2;

	localparam logic [1:0] MAT_A = 2'd0;
	localparam logic [1:0] MAT_B = 2'd1;
	localparam logic [1:0] MAT_C = 2'd2;
	localparam logic [1:0] MAT_D = 2'd3;

	localparam int SAMPLE_W = 16;
	localparam int STATE_W  = 24;
	localparam int COEF_W   = 18;
	localparam int ACC_W    = 52;

	// controller -> datapath commands
	typedef struct packed {
		logic clr;       // restart accumulator with this product
		logic mac;       // accumulate product
		logic use_x;     // operand from state vector (else input buffer)
		logic wr_xn;     // store rounded result into new-state temp
		logic commit_x;  // copy new state into state vector
		logic wr_y;      // load output register
	} sss_cmd_t;

endpackage

FILE: design/sss_datapath.sv
// Datapath: coefficient memory, state/input stores, one shared MAC.
// Depends on sss_pkg.
module sss_datapath #(
	parameter int NS = 4,
	parameter int NI = 2,
	parameter int FB = 14,
	parameter int DEPTH = 36,
	parameter int AW = 6
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          ld_coef,
	input  logic [AW-1:0]                 coef_waddr,
	input  logic signed [sss_pkg::COEF_W-1:0] coef_wdata,
	input  logic                          ld_state,
	input  logic [3:0]                    state_idx,
	input  logic signed [sss_pkg::STATE_W-1:0] state_wdata,
	input  logic                          ld_samp,
	input  logic [3:0]                    samp_idx,
	input  logic signed [sss_pkg::SAMPLE_W-1:0] samp_wdata,
	input  logic [AW-1:0]                 coef_raddr,
	input  logic                          coef_rd,
	input  logic [3:0]                    opnd_idx,
	input  logic [3:0]                    res_idx,
	input  sss_pkg::sss_cmd_t             cmd,
	output logic signed [sss_pkg::STATE_W-1:0] y_value
);
	import sss_pkg::*;

	localparam int XW = (NS > 1) ? $clog2(NS) : 1;
	localparam int UW = (NI > 1) ? $clog2(NI) : 1;

	logic [COEF_W-1:0]          mem [DEPTH];
	logic [DEPTH-1:0]           mvalid_q;
	logic signed [COEF_W-1:0]   coef_q;
	logic                       coef_ok_q;
	logic signed [STATE_W-1:0]  x_q  [NS];
	logic signed [STATE_W-1:0]  xn_q [NS];
	logic signed [SAMPLE_W-1:0] u_q  [NI];
	logic signed [STATE_W-1:0]  opnd_q;
	logic signed [ACC_W-1:0]    acc_q;
	logic signed [COEF_W-1:0]   coef_sel;
	logic signed [COEF_W+STATE_W-1:0] mul_s1;
	logic signed [ACC_W-1:0]    prod_s1;
	logic signed [ACC_W-1:0]    rnd;
	logic signed [ACC_W-1:0]    shf;
	logic signed [STATE_W-1:0]  sat_v;
	logic signed [STATE_W-1:0]  y_q;
	logic                       mac_s1;
	logic                       clr_s1;

	always_ff @(posedge clk) begin
		if (ld_coef)
			mem[coef_waddr] <= coef_wdata;
		if (coef_rd)
			coef_q <= mem[coef_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mvalid_q  <= '0;
			coef_ok_q <= 1'b0;
		end else begin
			if (ld_coef)
				mvalid_q[coef_waddr] <= 1'b1;
			if (coef_rd)
				coef_ok_q <= mvalid_q[coef_raddr];
		end
	end

	// last new-state element is still on sat_v when the commit happens
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NS; i++) x_q[i] <= '0;
			for (int i = 0; i < NI; i++) u_q[i] <= '0;
		end else begin
			if (ld_state)
				x_q[state_idx[XW-1:0]] <= state_wdata;
			if (cmd.commit_x) begin
				for (int i = 0; i < NS - 1; i++) x_q[i] <= xn_q[i];
				x_q[NS-1] <= sat_v;
			end
			if (ld_samp)
				u_q[samp_idx[UW-1:0]] <= samp_wdata;
		end
	end

	// operand fetch aligned with coefficient read
	always_ff @(posedge clk) begin
		if (coef_rd) begin
			if (cmd.use_x)
				opnd_q <= x_q[opnd_idx[XW-1:0]];
			else
				opnd_q <= STATE_W'(u_q[opnd_idx[UW-1:0]]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mac_s1 <= 1'b0;
			clr_s1 <= 1'b0;
		end else begin
			mac_s1 <= cmd.mac;
			clr_s1 <= cmd.clr;
		end
	end

	assign coef_sel = coef_ok_q ? coef_q : '0;
	assign mul_s1   = coef_sel * opnd_q;
	assign prod_s1  = ACC_W'(mul_s1);

	// first term of a sum loads the product directly
	always_ff @(posedge clk) begin
		if (clr_s1)
			acc_q <= prod_s1;
		else if (mac_s1)
			acc_q <= acc_q + prod_s1;
	end

	assign rnd = acc_q + (ACC_W'(1) <<< (FB - 1));
	assign shf = rnd >>> FB;
	always_comb begin
		if (shf > ACC_W'(24'sh7FFFFF))
			sat_v = 24'sh7FFFFF;
		else if (shf < -ACC_W'(25'sh0800000))
			sat_v = -24'sh800000;
		else
			sat_v = shf[STATE_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_xn)
			xn_q[res_idx[XW-1:0]] <= sat_v;
		if (cmd.wr_y)
			y_q <= sat_v;
	end

	assign y_value = y_q;

endmodule

FILE: design/sss_ctrl.sv
// Controller: sequences MAC passes for x update and y outputs.
// Depends on sss_pkg.
module sss_ctrl #(
	parameter int NS = 4,
	parameter int NI = 2,
	parameter int NO = 2,
	parameter int AW = 6
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	output logic              coef_rd,
	output logic [AW-1:0]     coef_raddr,
	output logic [3:0]        opnd_idx,
	output logic [3:0]        res_idx,
	output sss_pkg::sss_cmd_t cmd,
	output logic              y_valid,
	output logic [2:0]        y_index,
	output logic              y_last,
	input  logic              y_taken
);
	import sss_pkg::*;

	localparam int OFS_B = NS * NS;
	localparam int OFS_C = OFS_B + NS * NI;
	localparam int OFS_D = OFS_C + NO * NS;
	localparam int TERMS = NS + NI;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_ISSUE = 3'd1;
	localparam logic [2:0] ST_DRAIN = 3'd2;
	localparam logic [2:0] ST_WAIT  = 3'd3;
	localparam logic [2:0] ST_EMIT  = 3'd4;

	logic [2:0] st_q;
	logic       phase_q;  // 0 state update, 1 output
	logic [4:0] row_q;
	logic [4:0] term_q;
	logic [1:0] drain_q;
	logic [2:0] yidx_q;
	logic       ylast_q;
	logic       yv_q;
	logic       y_load;

	logic [4:0] nrows;
	assign nrows = phase_q ? 5'(NO) : 5'(NS);

	always_comb begin
		coef_raddr = '0;
		opnd_idx   = '0;
		if (!phase_q) begin
			if (term_q < 5'(NS)) begin
				coef_raddr = AW'(32'(row_q) * NS + 32'(term_q));
				opnd_idx   = term_q[3:0];
			end else begin
				coef_raddr = AW'(OFS_B + 32'(row_q) * NI + 32'(term_q) - NS);
				opnd_idx   = 4'(term_q - 5'(NS));
			end
		end else begin
			if (term_q < 5'(NS)) begin
				coef_raddr = AW'(OFS_C + 32'(row_q) * NS + 32'(term_q));
				opnd_idx   = term_q[3:0];
			end else begin
				coef_raddr = AW'(OFS_D + 32'(row_q) * NI + 32'(term_q) - NS);
				opnd_idx   = 4'(term_q - 5'(NS));
			end
		end
	end

	assign res_idx = row_q[3:0];
	assign coef_rd = (st_q == ST_ISSUE);
	// output register loads only once the previous beat has left
	assign y_load  = (st_q == ST_WAIT) && (!yv_q || y_taken);

	always_comb begin
		cmd          = '0;
		cmd.use_x    = term_q < 5'(NS);
		cmd.clr      = (st_q == ST_ISSUE) && (term_q == 5'd0);
		cmd.mac      = (st_q == ST_ISSUE);
		cmd.wr_xn    = (st_q == ST_DRAIN) && (drain_q == 2'd2) && !phase_q;
		cmd.wr_y     = y_load;
		cmd.commit_x = (st_q == ST_DRAIN) && (drain_q == 2'd2) && !phase_q
			&& (row_q == nrows - 5'd1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= ST_IDLE;
			phase_q <= 1'b0;
			row_q   <= '0;
			term_q  <= '0;
			drain_q <= '0;
			yidx_q  <= '0;
			ylast_q <= 1'b0;
			yv_q    <= 1'b0;
		end else begin
			if (y_load)
				yv_q <= 1'b1;
			else if (yv_q && y_taken)
				yv_q <= 1'b0;
			case (st_q)
				ST_IDLE: begin
					if (start) begin
						st_q    <= ST_ISSUE;
						phase_q <= 1'b0;
						row_q   <= '0;
						term_q  <= '0;
					end
				end
				ST_ISSUE: begin
					if (term_q == 5'(TERMS - 1)) begin
						st_q    <= ST_DRAIN;
						drain_q <= '0;
					end else begin
						term_q <= term_q + 5'd1;
					end
				end
				ST_DRAIN: begin
					drain_q <= drain_q + 2'd1;
					if (drain_q == 2'd2) begin
						term_q <= '0;
						if (phase_q) begin
							st_q <= ST_WAIT;
						end else if (row_q == nrows - 5'd1) begin
							phase_q <= 1'b1;
							row_q   <= '0;
							st_q    <= ST_ISSUE;
						end else begin
							row_q <= row_q + 5'd1;
							st_q  <= ST_ISSUE;
						end
					end
				end
				ST_WAIT: begin
					if (y_load) begin
						yidx_q  <= row_q[2:0];
						ylast_q <= (row_q == 5'(NO - 1));
						st_q    <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (row_q == 5'(NO - 1)) begin
						st_q <= ST_IDLE;
					end else begin
						row_q <= row_q + 5'd1;
						st_q  <= ST_ISSUE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	assign busy    = (st_q != ST_IDLE);
	assign y_valid = yv_q;
	assign y_index = yidx_q;
	assign y_last  = ylast_q;

endmodule

FILE: design/state_space_system_step.sv
// Top level of the state-space step block: decode, controller, datapath.
// Depends on sss_pkg, sss_ctrl, sss_datapath.
//
//  channel | dir | carries
//  s_axis  | in  | action, row, col, matrix_sel, value (tdata), last_element (tlast)
//  m_axis  | out | out_index, out_value (tdata), out_last (tlast)
//
// A sample beat with tlast starts a step, run on the single shared MAC unit.
// s_axis_tready is low during a step; other beats are taken whenever it is high.
// Each result waits in the output register; the step stalls there until taken.
module state_space_system_step #(
	parameter int NUM_STATES     = 4,
	parameter int NUM_INPUTS     = 2,
	parameter int NUM_OUTPUTS    = 2,
	parameter int COEF_FRAC_BITS = 14
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,  // action[1:0] row[5:2] col[9:6] matrix_sel[11:10] value[35:12]
	input  logic        s_axis_tlast,  // last_element
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,  // out_index[2:0] out_value[26:3]
	output logic        m_axis_tlast   // out_last
);
	import sss_pkg::*;

	localparam int DEPTH = NUM_STATES * NUM_STATES + NUM_STATES * NUM_INPUTS
		+ NUM_OUTPUTS * NUM_STATES + NUM_OUTPUTS * NUM_INPUTS;
	localparam int AW = $clog2(DEPTH);
	localparam int OFS_B = NUM_STATES * NUM_STATES;
	localparam int OFS_C = OFS_B + NUM_STATES * NUM_INPUTS;
	localparam int OFS_D = OFS_C + NUM_OUTPUTS * NUM_STATES;

	logic [1:0]  action;
	logic [3:0]  row;
	logic [3:0]  col;
	logic [1:0]  msel;
	logic signed [23:0] value;
	logic        beat;
	logic        busy;
	logic [4:0]  rows;
	logic [4:0]  cols;
	logic [AW-1:0] waddr;
	logic        ld_coef;
	logic        ld_state;
	logic        ld_samp;
	logic signed [COEF_W-1:0]   cval;
	logic signed [SAMPLE_W-1:0] sval;
	logic        coef_rd;
	logic [AW-1:0] raddr;
	logic [3:0]  opnd_idx;
	logic [3:0]  res_idx;
	sss_cmd_t    cmd;
	logic signed [STATE_W-1:0] y_value;
	logic [2:0]  y_index;

	assign action = s_axis_tdata[1:0];
	assign row    = s_axis_tdata[5:2];
	assign col    = s_axis_tdata[9:6];
	assign msel   = s_axis_tdata[11:10];
	assign value  = s_axis_tdata[35:12];

	assign s_axis_tready = !busy;
	assign beat = s_axis_tvalid && s_axis_tready;

	always_comb begin
		rows = (msel == MAT_A || msel == MAT_B) ? 5'(NUM_STATES) : 5'(NUM_OUTPUTS);
		cols = (msel == MAT_A || msel == MAT_C) ? 5'(NUM_STATES) : 5'(NUM_INPUTS);
		case (msel)
			MAT_A:   waddr = AW'(32'(row) * NUM_STATES + 32'(col));
			MAT_B:   waddr = AW'(OFS_B + 32'(row) * NUM_INPUTS + 32'(col));
			MAT_C:   waddr = AW'(OFS_C + 32'(row) * NUM_STATES + 32'(col));
			default: waddr = AW'(OFS_D + 32'(row) * NUM_INPUTS + 32'(col));
		endcase
		if (value > 24'sd131071)       cval = 18'sh1FFFF;
		else if (value < -24'sd131072) cval = -18'sh20000;
		else                           cval = value[17:0];
		if (value > 24'sd32767)        sval = 16'sh7FFF;
		else if (value < -24'sd32768)  sval = -16'sh8000;
		else                           sval = value[15:0];
	end

	assign ld_coef  = beat && action == ACT_COEF && {1'b0, row} < rows && {1'b0, col} < cols;
	assign ld_state = beat && action == ACT_STATE && {1'b0, row} < 5'(NUM_STATES);
	assign ld_samp  = beat && action == ACT_SAMPLE && {1'b0, row} < 5'(NUM_INPUTS);

	sss_ctrl #(.NS(NUM_STATES), .NI(NUM_INPUTS), .NO(NUM_OUTPUTS), .AW(AW)) u_ctrl (
		.clk, .arst_n,
		.start(beat && action == ACT_SAMPLE && s_axis_tlast),
		.busy, .coef_rd, .coef_raddr(raddr), .opnd_idx, .res_idx, .cmd,
		.y_valid(m_axis_tvalid), .y_index, .y_last(m_axis_tlast),
		.y_taken(m_axis_tready)
	);

	sss_datapath #(.NS(NUM_STATES), .NI(NUM_INPUTS),
		.FB(COEF_FRAC_BITS), .DEPTH(DEPTH), .AW(AW)) u_dp (
		.clk, .arst_n,
		.ld_coef, .coef_waddr(waddr), .coef_wdata(cval),
		.ld_state, .state_idx(row), .state_wdata(value),
		.ld_samp, .samp_idx(row), .samp_wdata(sval),
		.coef_raddr(raddr), .coef_rd, .opnd_idx, .res_idx, .cmd,
		.y_value
	);

	assign m_axis_tdata = {5'd0, y_value, y_index};

endmodule
